FILE: design/rpta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range pair tilt angles package
// Shared constants and the CORDIC arctangent table for the tilt angle core.
// ----------------------------------------------------------------------------
package rpta_pkg;

  localparam int CORDIC_STEPS_DEF = 14;
  localparam int DIST_BITS_DEF    = 13;

  localparam int SPACING_W        = 8;
  localparam logic [SPACING_W-1:0] SPACING_RST = 8'd40;

  // Operands are scaled by 2^FRAC_SHIFT, the angle accumulates in Q16.
  localparam int FRAC_SHIFT  = 16;
  localparam int ATAN_W      = 19;
  localparam int ANGLE_W     = 15;
  localparam int ANGLE_MAX   = 12868;
  localparam int ROUND_SHIFT = 3;
  localparam int ATAN_LEN    = 20;
  localparam int OUT_TDATA_W = 32;

  // round(atan(2^-i) * 2^16); steps past the end of the table add nothing.
  function automatic logic [ATAN_W-1:0] atan_q16(input int step);
    logic [ATAN_W-1:0] a;
    begin
      case (step)
        0:       a = 19'd51472;
        1:       a = 19'd30386;
        2:       a = 19'd16055;
        3:       a = 19'd8150;
        4:       a = 19'd4091;
        5:       a = 19'd2047;
        6:       a = 19'd1024;
        7:       a = 19'd512;
        8:       a = 19'd256;
        9:       a = 19'd128;
        10:      a = 19'd64;
        11:      a = 19'd32;
        12:      a = 19'd16;
        13:      a = 19'd8;
        14:      a = 19'd4;
        15:      a = 19'd2;
        16:      a = 19'd1;
        default: a = '0;
      endcase
      return a;
    end
  endfunction

endpackage

FILE: design/range_pair_tilt_angles_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range pair tilt angles core
// Roll and pitch from two pairs of range sensors by pipelined CORDIC vectoring.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one sample set per transfer: four distances in
//   millimetres. Roll is atan2(dist_0 - dist_1, spacing) and pitch is
//   atan2(dist_2 - dist_3, spacing), both as signed Q13 radians saturated to
//   plus or minus pi/2. The spacing comes from the configuration channel,
//   which always accepts a write; it resets to 40 mm and should only be
//   changed while no sample set is in flight.
//   On the way from an input transfer to a valid result, the entry stage that
//   forms the differences is loaded at the input transfer, then one register
//   stage per CORDIC iteration follows, and the rounding/output register comes
//   last. A new sample set can be taken in every cycle while the pipeline is
//   not full; the throughput of one set per cycle is set by the
//   one-iteration-per-stage CORDIC pipeline.
//   Every stage has its own valid bit and advances when the stage after it
//   is empty or moving, so bubbles collapse and a held result does not stop
//   earlier stages from filling. When the receiver stalls long enough for
//   every stage to be full, in_tready drops. Reset empties the pipeline and
//   restores the default spacing.
// ----------------------------------------------------------------------------
module range_pair_tilt_angles_core #(
  parameter int CORDIC_STEPS = rpta_pkg::CORDIC_STEPS_DEF,
  parameter int DIST_BITS    = rpta_pkg::DIST_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,

  // dist_0, dist_1, dist_2, dist_3 from the lowest bit up, zero padded
  input  logic [((4*DIST_BITS+7)/8)*8-1:0] in_tdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,

  // roll_angle, pitch_angle from the lowest bit up, zero padded
  output logic [rpta_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,

  input  logic [rpta_pkg::SPACING_W-1:0]   cfg_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready
);
  import rpta_pkg::*;

  // Datapath width: the vector length stays below 2^(DIST_BITS+1), the
  // CORDIC gain is under two, plus the sign bit.
  localparam int W      = DIST_BITS + FRAC_SHIFT + 3;
  localparam int LANES  = 2;
  localparam int STAGES = CORDIC_STEPS + 1;

  // Configuration register.
  logic [SPACING_W-1:0] spacing_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_r <= SPACING_RST;
    end else if (cfg_valid) begin
      spacing_r <= cfg_data;
    end
  end

  // Pipeline state. Stage 0 holds the prepared operands, stage k holds the
  // vector after k iterations.
  logic                     v_r    [0:STAGES-1];
  logic                     rdy    [0:STAGES];
  logic signed [W-1:0]      x_r    [0:LANES-1][0:STAGES-1];
  logic signed [W-1:0]      y_r    [0:LANES-1][0:STAGES-1];
  logic signed [ATAN_W-1:0] z_r    [0:LANES-1][0:STAGES-1];
  logic                     neg_r  [0:LANES-1][0:STAGES-1];
  logic                     zero_r [0:LANES-1][0:STAGES-1];

  logic                     out_valid_r;
  logic [ANGLE_W-1:0]       angle_r   [0:LANES-1];
  logic [ANGLE_W-1:0]       angle_nxt [0:LANES-1];

  // A stage can take a new item when it is empty or its item moves on.
  assign rdy[STAGES] = !out_valid_r || out_tready;

  genvar s, l;
  generate
    for (s = 0; s < STAGES; s++) begin : g_rdy
      assign rdy[s] = !v_r[s] || rdy[s+1];
    end
  endgenerate

  assign in_tready = rdy[0];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < STAGES; k++) begin
        v_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
      if (rdy[STAGES]) begin
        out_valid_r <= v_r[STAGES-1];
      end
    end
  end

  generate
    for (l = 0; l < LANES; l++) begin : g_lane
      // Entry stage: signed difference, its magnitude and sign.
      logic [DIST_BITS-1:0]      dist_a;
      logic [DIST_BITS-1:0]      dist_b;
      logic signed [DIST_BITS:0] diff;
      logic [DIST_BITS:0]        mag;

      // Output stage signals.
      logic signed [ATAN_W:0]             z_rnd;
      logic signed [ATAN_W-ROUND_SHIFT:0] q;
      logic signed [ANGLE_W-1:0]          q_sat;

      assign dist_a = in_tdata[(2*l)*DIST_BITS +: DIST_BITS];
      assign dist_b = in_tdata[(2*l+1)*DIST_BITS +: DIST_BITS];
      assign diff   = $signed({1'b0, dist_a}) - $signed({1'b0, dist_b});
      assign mag    = diff[DIST_BITS] ? (DIST_BITS+1)'(0) - diff : diff;

      always_ff @(posedge clk) begin
        if (rdy[0] && in_tvalid) begin
          x_r[l][0]    <= $signed({{(W-SPACING_W-FRAC_SHIFT){1'b0}}, spacing_r,
                                   {FRAC_SHIFT{1'b0}}});
          y_r[l][0]    <= $signed({{(W-DIST_BITS-1-FRAC_SHIFT){1'b0}},
                                   mag, {FRAC_SHIFT{1'b0}}});
          z_r[l][0]    <= '0;
          neg_r[l][0]  <= diff[DIST_BITS];
          zero_r[l][0] <= (diff == '0);
        end
      end

      // One CORDIC vectoring iteration per stage.
      for (s = 0; s < CORDIC_STEPS; s++) begin : g_step
        logic signed [W-1:0]      xs;
        logic signed [W-1:0]      ys;
        logic signed [ATAN_W-1:0] ang;

        assign xs  = x_r[l][s] >>> s;
        assign ys  = y_r[l][s] >>> s;
        assign ang = $signed(atan_q16(s));

        always_ff @(posedge clk) begin
          if (rdy[s+1] && v_r[s]) begin
            if (!y_r[l][s][W-1]) begin
              x_r[l][s+1] <= x_r[l][s] + ys;
              y_r[l][s+1] <= y_r[l][s] - xs;
              z_r[l][s+1] <= z_r[l][s] + ang;
            end else begin
              x_r[l][s+1] <= x_r[l][s] - ys;
              y_r[l][s+1] <= y_r[l][s] + xs;
              z_r[l][s+1] <= z_r[l][s] - ang;
            end
            neg_r[l][s+1]  <= neg_r[l][s];
            zero_r[l][s+1] <= zero_r[l][s];
          end
        end
      end

      // Round Q16 to Q13 with a half-LSB offset, saturate, then restore the
      // sign of the difference. Equal distances give exactly zero.
      assign z_rnd = $signed({z_r[l][STAGES-1][ATAN_W-1], z_r[l][STAGES-1]})
                     + $signed((ATAN_W+1)'(4));
      assign q     = z_rnd[ATAN_W:ROUND_SHIFT];

      always_comb begin
        if (q > $signed((ATAN_W-ROUND_SHIFT+1)'(ANGLE_MAX))) begin
          q_sat = ANGLE_W'(ANGLE_MAX);
        end else if (q < -$signed((ATAN_W-ROUND_SHIFT+1)'(ANGLE_MAX))) begin
          q_sat = -ANGLE_W'(ANGLE_MAX);
        end else begin
          q_sat = q[ANGLE_W-1:0];
        end
        if (zero_r[l][STAGES-1]) begin
          angle_nxt[l] = '0;
        end else if (neg_r[l][STAGES-1]) begin
          angle_nxt[l] = -q_sat;
        end else begin
          angle_nxt[l] = q_sat;
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[STAGES] && v_r[STAGES-1]) begin
          angle_r[l] <= angle_nxt[l];
        end
      end
    end
  endgenerate

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-2*ANGLE_W){1'b0}}, angle_r[1], angle_r[0]};

  // Checks on the pipeline control and the result range.
  logic signed [ANGLE_W-1:0] roll_chk;
  logic signed [ANGLE_W-1:0] pitch_chk;
  logic                      all_full;

  assign roll_chk  = $signed(angle_r[0]);
  assign pitch_chk = $signed(angle_r[1]);

  always_comb begin
    all_full = out_valid_r;
    for (int k = 0; k < STAGES; k++) begin
      all_full = all_full && v_r[k];
    end
  end

  a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (roll_chk <= ANGLE_MAX) && (roll_chk >= -ANGLE_MAX))
    else $error("roll angle outside saturation range");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (pitch_chk <= ANGLE_MAX) && (pitch_chk >= -ANGLE_MAX))
    else $error("pitch angle outside saturation range");

  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> all_full && !out_tready)
    else $error("input stalled while the pipeline has room");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid && in_tready)
    else $error("pipeline not empty after reset");

endmodule
